>>> hdl/pfdc_pkg.sv
// Shared types, sizes and helpers for the packet FIFO with duplicate filter.
// No dependencies; every other file of the block imports this package.
package pfdc_pkg;

  localparam int DEPTH     = 256;
  localparam int OCC_W     = $clog2(DEPTH + 1);
  localparam int CFG_W     = 9;
  localparam int CNT_W     = 9;
  localparam int CMP_W     = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam int CHUNK     = 32;
  localparam int NCHUNK    = (DEPTH + CHUNK - 1) / CHUNK;
  localparam int VEC_W     = NCHUNK * CHUNK;
  localparam int LEFT_W    = $clog2(NCHUNK + 1);
  localparam int ACC_W     = $clog2(DEPTH + 1);
  localparam int SAT_W     = (ACC_W > CNT_W) ? ACC_W : CNT_W;
  localparam int CNT_MAX   = 511;
  localparam int CAP_RESET = 256;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_FWD   = 2'd1;
  localparam logic [1:0] ACT_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } pfdc_in_t;

  typedef struct packed {
    logic        accepted;
    logic        out_valid;
    logic [15:0] out_source;
    logic [15:0] out_destination;
    logic [31:0] out_timestamp;
    logic [8:0]  match_count;
  } pfdc_out_t;

  typedef struct packed {
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
  } pfdc_entry_t;

  typedef struct packed {
    logic capture;   // register compare results against the incoming request
    logic shift;     // take the right neighbor's entry
    logic write;     // load the new packet
    logic occupied;  // this slot holds a stored packet
  } pfdc_cell_ctrl_t;

  function automatic logic [3:0] pfdc_pop8(input logic [7:0] bits);
    logic [3:0] n;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      n = n + 4'(bits[b]);
    end
    return n;
  endfunction

  function automatic logic [5:0] pfdc_pop32(input logic [31:0] bits);
    return 6'(pfdc_pop8(bits[7:0])) + 6'(pfdc_pop8(bits[15:8]))
         + 6'(pfdc_pop8(bits[23:16])) + 6'(pfdc_pop8(bits[31:24]));
  endfunction

endpackage

>>> hdl/packet_fifo_with_dedup_and_count_core.sv
// Top level of the packet FIFO with duplicate filter and windowed count.
// Depends on pfdc_pkg, pfdc_cell and pfdc_counter.
//
//   channel   | ports                          | transaction
//   ----------+--------------------------------+-------------------------------
//   request   | start, busy, in_i              | start high while busy low
//   result    | done_o, out_o                  | done_o high, one cycle, no stall
//   config    | cfg_we_i, cfg_wdata_i          | cfg_we_i high (capacity)
//
// For add and forward, the request edge registers every slot's compare flags and
// the next edge updates the chain. For count, the counter is loaded from the match
// flags and sums them 32 per cycle. The result is registered at the edge that
// finishes the work and shows in the cycle where busy is already low.
// Reset empties the FIFO and sets capacity to 256; slot contents are not cleared.
module packet_fifo_with_dedup_and_count_core
  import pfdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pfdc_in_t         in_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output pfdc_out_t        out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COUNT
  } state_e;

  state_e           state_q;
  pfdc_in_t         req_q;
  logic [OCC_W-1:0] occ_q;
  logic [CFG_W-1:0] cap_q;
  logic             done_q, done_d;
  pfdc_out_t        out_q, out_d;

  pfdc_entry_t      ent [DEPTH];
  pfdc_cell_ctrl_t  ctrl [DEPTH];
  logic [DEPTH-1:0] dup_vec;
  logic [DEPTH-1:0] match_vec;
  logic [VEC_W-1:0] match_pad;
  pfdc_entry_t      new_entry;

  logic             accept;
  logic             dup_any;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             evict;
  logic             add_go;
  logic             do_shift;
  logic [OCC_W-1:0] wpos;
  logic             cnt_load;
  logic             cnt_done;
  logic [CNT_W-1:0] cnt_value;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Effective capacity: zero acts as one, anything above DEPTH acts as DEPTH.
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end
    evict = (CMP_W'(occ_q) >= eff_cap);
  end

  assign dup_any = |dup_vec;

  always_comb begin
    new_entry.source      = req_q.source;
    new_entry.destination = req_q.destination;
    new_entry.timestamp   = req_q.timestamp;
  end

  // Decide the chain operation for the request held in req_q.
  always_comb begin
    add_go   = 1'b0;
    do_shift = 1'b0;
    cnt_load = 1'b0;
    if (state_q == S_EXEC) begin
      case (req_q.action)
        ACT_ADD: begin
          add_go   = !dup_any;
          do_shift = !dup_any && evict;
        end
        ACT_FWD: begin
          do_shift = (occ_q != '0);
        end
        ACT_COUNT: begin
          cnt_load = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // Append after the newest entry; when evicting, the chain shifts down by one first.
    wpos = evict ? (occ_q - OCC_W'(1)) : occ_q;
  end

  // Row of slots; slot 0 is the oldest packet, each slot pulls from its right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [OCC_W-1:0] IDX = OCC_W'(i);
    pfdc_entry_t next_entry;

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = ent[i+1];
    end

    always_comb begin
      ctrl[i].capture  = accept;
      ctrl[i].shift    = do_shift;
      ctrl[i].write    = add_go && (IDX == wpos);
      ctrl[i].occupied = (IDX < occ_q);
    end

    pfdc_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[i]),
      .key_i      (in_i),
      .wr_entry_i (new_entry),
      .next_i     (next_entry),
      .entry_o    (ent[i]),
      .dup_o      (dup_vec[i]),
      .match_o    (match_vec[i])
    );
  end

  // Pad the match flags up to whole chunks.
  always_comb begin
    match_pad            = '0;
    match_pad[DEPTH-1:0] = match_vec;
  end

  pfdc_counter u_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cnt_load),
    .match_i (match_pad),
    .done_o  (cnt_done),
    .count_o (cnt_value)
  );

  // Strobe the result at the edge that finishes the work.
  assign done_d = ((state_q == S_EXEC) && (req_q.action != ACT_COUNT))
               || ((state_q == S_COUNT) && cnt_done);

  // Result fields for the transaction that finishes at the next edge (a count clears them in S_EXEC); hold otherwise.
  always_comb begin
    out_d = out_q;
    if (state_q == S_EXEC) begin
      out_d = '0;
      case (req_q.action)
        ACT_ADD: begin
          out_d.accepted = add_go;
        end
        ACT_FWD: begin
          if (occ_q != '0) begin
            out_d.out_valid       = 1'b1;
            out_d.out_source      = ent[0].source;
            out_d.out_destination = ent[0].destination;
            out_d.out_timestamp   = ent[0].timestamp;
          end
        end
        default: begin
        end
      endcase
    end else if ((state_q == S_COUNT) && cnt_done) begin
      out_d             = '0;
      out_d.match_count = cnt_value;
    end
  end

  // Sequencer, occupancy, capacity register and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      cap_q   <= CFG_W'(CAP_RESET);
      done_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (req_q.action)
            ACT_ADD: begin
              state_q <= S_IDLE;
              if (add_go && !evict) begin
                occ_q <= occ_q + OCC_W'(1);
              end
            end
            ACT_FWD: begin
              state_q <= S_IDLE;
              if (occ_q != '0) begin
                occ_q <= occ_q - OCC_W'(1);
              end
            end
            ACT_COUNT: begin
              state_q <= S_COUNT;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_COUNT: begin
          if (cnt_done) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request hold and result fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_i;
    end
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  // Occupancy never exceeds the slot count.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(occ_q) <= CMP_W'(DEPTH))
    else $error("occupancy exceeds depth");

  // A request always leaves the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  // A result strobe only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  // An add result and a forward result are never reported together.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(out_o.accepted && out_o.out_valid))
    else $error("add and forward flags both set");

  // A forward that reports a packet always lowers the occupancy.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.out_valid) |-> (occ_q < $past(occ_q, 1)))
    else $error("forward reported a packet without popping one");

endmodule

>>> hdl/pfdc_cell.sv
// One storage slot of the packet chain: holds an entry, shifts toward the head,
// and registers its duplicate and window-match flags. Depends on pfdc_pkg.
module pfdc_cell
  import pfdc_pkg::*;
(
  input  logic            clk_i,
  input  pfdc_cell_ctrl_t ctrl_i,
  input  pfdc_in_t        key_i,
  input  pfdc_entry_t     wr_entry_i,
  input  pfdc_entry_t     next_i,
  output pfdc_entry_t     entry_o,
  output logic            dup_o,
  output logic            match_o
);

  pfdc_entry_t entry_q, entry_d;
  logic        dup_q, dup_d;
  logic        match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = next_i;
    end
    if (ctrl_i.write) begin
      entry_d = wr_entry_i;
    end
    dup_d = ctrl_i.occupied
         && (entry_q.source == key_i.source)
         && (entry_q.destination == key_i.destination)
         && (entry_q.timestamp == key_i.timestamp);
    match_d = ctrl_i.occupied
           && (entry_q.destination == key_i.destination)
           && (entry_q.timestamp >= key_i.start_time)
           && (entry_q.timestamp <= key_i.end_time);
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.capture) begin
      dup_q   <= dup_d;
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign dup_o   = dup_q;
  assign match_o = match_q;

endmodule

>>> hdl/pfdc_counter.sv
// Chunked population count of the window-match flags, 32 flags per cycle,
// saturated to the result width. Depends on pfdc_pkg.
module pfdc_counter
  import pfdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [VEC_W-1:0] match_i,
  output logic             done_o,
  output logic [CNT_W-1:0] count_o
);

  logic [VEC_W-1:0]  vec_q, vec_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  sum;
  logic [SAT_W-1:0]  sum_ext;

  always_comb begin
    sum     = acc_q + ACC_W'(pfdc_pop32(vec_q[CHUNK-1:0]));
    sum_ext = SAT_W'(sum);
    count_o = (sum_ext > SAT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(sum_ext);
    done_o  = (left_q == LEFT_W'(1));
    vec_d   = vec_q;
    left_d  = left_q;
    acc_d   = acc_q;
    if (load_i) begin
      vec_d  = match_i;
      left_d = LEFT_W'(NCHUNK);
      acc_d  = '0;
    end else if (left_q != '0) begin
      vec_d  = vec_q >> CHUNK;
      left_d = left_q - LEFT_W'(1);
      acc_d  = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
    acc_q <= acc_d;
  end

endmodule

>>> dv/packet_fifo_with_dedup_and_count_core_tb.sv
// Self-checking testbench for packet_fifo_with_dedup_and_count_core.
// Depends on pfdc_pkg and the block's RTL. It predicts every result with its own packet store.
`timescale 1ns / 100ps

module packet_fifo_with_dedup_and_count_core_tb;
  import pfdc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;   // no operation: state holds, result is all zero
  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 3;
  localparam int DRAIN_CYCLES = 16;           // idle margin after the last owed result returns
  localparam int STALL_LIMIT  = 2000;         // cycles with no transaction before giving up
  localparam int REPORT_MAX   = 10;
  localparam int HISTORY_MAX  = 16;

  // Packet store predictor: a circular buffer of DEPTH slots, of which the live
  // capacity is used, plus the results that are still owed by the block.
  class packet_store_model;
    pfdc_entry_t slots [DEPTH];
    int unsigned head = 0;
    int unsigned tail = 0;
    int unsigned fill = 0;
    int unsigned cap_reg = CAP_RESET;
    pfdc_out_t   pending_results [$];
    int unsigned err_count = 0;

    function int unsigned live_capacity();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    // Apply one accepted request to the store and queue the result it owes.
    function void absorb_request(pfdc_in_t req);
      pfdc_out_t   res;
      pfdc_entry_t pkt;
      bit          dup;
      int unsigned n;
      int unsigned s;
      res = '0;
      pkt = '{source: req.source, destination: req.destination, timestamp: req.timestamp};
      case (req.action)
        ACT_ADD: begin
          dup = 1'b0;
          for (int k = 0; k < fill; k++) begin
            if (slots[(head + k) % DEPTH] == pkt) dup = 1'b1;
          end
          if (!dup) begin
            // Full (or capacity lowered below occupancy): drop the oldest first.
            if (fill >= live_capacity()) begin
              head = (head + 1) % DEPTH;
              fill--;
            end
            slots[tail] = pkt;
            tail = (tail + 1) % DEPTH;
            fill++;
            res.accepted = 1'b1;
          end
        end
        ACT_FWD: begin
          if (fill != 0) begin
            res.out_valid       = 1'b1;
            res.out_source      = slots[head].source;
            res.out_destination = slots[head].destination;
            res.out_timestamp   = slots[head].timestamp;
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        ACT_COUNT: begin
          n = 0;
          for (int k = 0; k < fill; k++) begin
            s = (head + k) % DEPTH;
            if (slots[s].destination == req.destination &&
                slots[s].timestamp >= req.start_time &&
                slots[s].timestamp <= req.end_time) n++;
          end
          if (n > CNT_MAX) n = CNT_MAX;
          res.match_count = CNT_W'(n);
        end
        default: ;
      endcase
      pending_results.insert(pending_results.size(), res);
    endfunction

    // Compare one result from the block against the oldest owed result.
    function void check_result(pfdc_out_t got);
      pfdc_out_t want;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("[%0t] unexpected result: acc=%0b vld=%0b src=%h dst=%h ts=%h cnt=%0d",
                   $realtime, got.accepted, got.out_valid, got.out_source,
                   got.out_destination, got.out_timestamp, got.match_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.accepted !== want.accepted || got.out_valid !== want.out_valid ||
          got.out_source !== want.out_source ||
          got.out_destination !== want.out_destination ||
          got.out_timestamp !== want.out_timestamp ||
          got.match_count !== want.match_count) begin
        err_count++;
        if (err_count <= REPORT_MAX) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected acc=%0b vld=%0b src=%h dst=%h ts=%h cnt=%0d",
                   want.accepted, want.out_valid, want.out_source,
                   want.out_destination, want.out_timestamp, want.match_count);
          $display("  actual   acc=%0b vld=%0b src=%h dst=%h ts=%h cnt=%0d",
                   got.accepted, got.out_valid, got.out_source,
                   got.out_destination, got.out_timestamp, got.match_count);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  pfdc_in_t         in_i;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             done_o;
  pfdc_out_t        out_o;

  packet_store_model model;
  int                idle_pct;
  int                stall_cycles;
  logic [31:0]       ts_clock;
  pfdc_entry_t       recent_pkts [$];

  packet_fifo_with_dedup_and_count_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .out_o      (out_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Collect every result in the cycle it is shown; the receiver never stalls.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) model.check_result(out_o);
  end

  // Watchdog: restart on any transaction in either direction, else count up.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** packet_fifo_with_dedup_and_count_core: FAILED **");
      $finish;
    end
  end

  // Fill every input field with random bits; callers overwrite what matters.
  function automatic pfdc_in_t random_fields();
    logic [159:0] noise;
    pfdc_in_t     req;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    req = noise[$bits(pfdc_in_t)-1:0];
    return req;
  endfunction

  function automatic pfdc_in_t make_req(logic [1:0] act, logic [15:0] src, logic [15:0] dst,
                                        logic [31:0] ts, logic [31:0] lo, logic [31:0] hi);
    pfdc_in_t req;
    req = '{action: act, source: src, destination: dst, timestamp: ts,
            start_time: lo, end_time: hi};
    return req;
  endfunction

  // Node ids come mostly from a tiny pool so that duplicates and count hits are common.
  function automatic logic [15:0] pick_node();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(3));
    if (r < 70) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Fresh timestamps advance a running clock (steps of 0 allowed); the rest are
  // pool values, the maximum, or fully random.
  function automatic logic [31:0] pick_stamp(int fresh_pct);
    int r;
    r = $urandom_range(99);
    if (r < fresh_pct) begin
      ts_clock = ts_clock + 32'($urandom_range(2));
      return ts_clock;
    end
    r = $urandom_range(99);
    if (r < 60) return 32'($urandom_range(7));
    if (r < 75) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic pfdc_in_t random_request(int add_pct, int fwd_pct, int cnt_pct,
                                              int fresh_pct);
    pfdc_in_t    req;
    pfdc_entry_t pkt;
    int          pick;
    int          r;
    req  = random_fields();
    pick = $urandom_range(99);
    if (pick < add_pct) begin
      req.action = ACT_ADD;
      if (recent_pkts.size() != 0 && $urandom_range(99) < 15) begin
        // Re-add a recent packet: a duplicate if still stored, a fresh add if gone.
        pkt = recent_pkts[$urandom_range(recent_pkts.size() - 1)];
      end else begin
        pkt = '{source: pick_node(), destination: pick_node(), timestamp: pick_stamp(fresh_pct)};
      end
      req.source      = pkt.source;
      req.destination = pkt.destination;
      req.timestamp   = pkt.timestamp;
      recent_pkts.insert(recent_pkts.size(), pkt);
      if (recent_pkts.size() > HISTORY_MAX) void'(recent_pkts.pop_front());
    end else if (pick < add_pct + fwd_pct) begin
      req.action = ACT_FWD;
    end else if (pick < add_pct + fwd_pct + cnt_pct) begin
      req.action      = ACT_COUNT;
      req.destination = pick_node();
      r = $urandom_range(99);
      if (r < 35) begin
        req.start_time = 32'($urandom_range(7));
        req.end_time   = 32'($urandom_range(7));
      end else if (r < 50) begin
        req.start_time = '0;
        req.end_time   = '1;
      end else if (r < 75) begin
        req.start_time = ts_clock - 32'($urandom_range(20));
        req.end_time   = req.start_time + 32'($urandom_range(30));
      end else if (r < 85) begin
        // Empty window: the lower bound lies past the upper one.
        req.end_time   = ts_clock - 32'($urandom_range(10));
        req.start_time = req.end_time + 32'($urandom_range(1, 5));
      end
    end else begin
      req.action = ACT_UNUSED;
    end
    return req;
  endfunction

  // Present one request and hold it until the block takes it; then idle at random.
  task automatic send_request(input pfdc_in_t req);
    bit taken;
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= req;
    do begin
      @(posedge clk_i);
      taken = !busy;
    end while (!taken);
    model.absorb_request(req);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      in_i  <= random_fields();
      @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every owed result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model.cap_reg = value;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cap, input int n_items, input int idle,
                           input int add_pct, input int fwd_pct, input int cnt_pct,
                           input int fresh_pct);
    write_capacity(cap);
    idle_pct = idle;
    repeat (n_items) send_request(random_request(add_pct, fwd_pct, cnt_pct, fresh_pct));
  endtask

  initial begin
    model        = new;
    idle_pct     = 0;
    ts_clock     = 32'd100;
    rst_ni       = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    stall_cycles = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, unused code, field extremes, duplicates, windows.
    // Capacity is still at its reset value here.
    send_request(make_req(ACT_FWD, '0, '0, '0, '0, '0));
    send_request(make_req(ACT_COUNT, '0, '0, '0, '0, '1));
    send_request(make_req(ACT_UNUSED, '1, '1, '1, '1, '1));
    send_request(make_req(ACT_ADD, '0, '0, '0, '1, '1));
    send_request(make_req(ACT_ADD, '1, '1, '1, '0, '0));
    send_request(make_req(ACT_ADD, '0, '0, '0, '0, '0));         // duplicate
    send_request(make_req(ACT_ADD, '0, '0, 32'd1, '0, '0));
    send_request(make_req(ACT_ADD, '1, '0, '0, '0, '0));         // differs in source only
    send_request(make_req(ACT_COUNT, '1, '0, '1, '0, '1));
    send_request(make_req(ACT_COUNT, '0, '0, '0, 32'd1, '0));    // empty window
    send_request(make_req(ACT_COUNT, '0, '1, '0, '1, '1));
    send_request(make_req(ACT_COUNT, '0, '0, '0, 32'd1, 32'd1));
    send_request(make_req(ACT_UNUSED, '0, '0, '0, '0, '0));
    repeat (5) send_request(make_req(ACT_FWD, '1, '1, '1, '1, '1));
    send_request(make_req(ACT_ADD, '0, '0, '0, '0, '0));         // re-add after forward
    // Tiny capacity: the second and third adds each evict the oldest.
    write_capacity(9'd2);
    send_request(make_req(ACT_ADD, 16'd1, 16'd2, 32'd3, '0, '0));
    send_request(make_req(ACT_ADD, 16'd4, 16'd5, 32'd6, '0, '0));
    send_request(make_req(ACT_ADD, '0, '0, '0, '0, '0));         // evicted, so accepted
    send_request(make_req(ACT_COUNT, '0, 16'd2, '0, '0, '1));
    repeat (3) send_request(make_req(ACT_FWD, '0, '0, '0, '0, '0));

    // Random phases: capacity extremes and out-of-range values, mixed idling.
    run_phase(9'd1,    60,  0, 50, 25, 20, 30);
    run_phase(9'd0,    50, 63, 50, 25, 20, 30);
    run_phase(9'd3,    70, 38, 55, 20, 20, 30);
    // Mostly fresh adds: fill past DEPTH so eviction at full depth happens.
    run_phase(9'd511, 400, 38, 91,  2,  6, 85);
    // Capacity far below occupancy: each accepted add evicts exactly one.
    run_phase(9'd4,    60, 63, 55, 20, 22, 30);
    run_phase(9'd2,    60,  0, 45, 30, 20, 30);
    run_phase(9'd300,  60, 63, 55, 20, 20, 40);
    run_phase(9'd256,  60, 38, 55, 20, 20, 40);
    run_phase(9'd16,   60,  0, 50, 25, 20, 30);

    drain_results();
    if (model.err_count == 0 && model.pending_results.size() == 0) begin
      $display("** packet_fifo_with_dedup_and_count_core: PASSED **");
    end else begin
      $display("** packet_fifo_with_dedup_and_count_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pfdc_pkg.sv
hdl/pfdc_cell.sv
hdl/pfdc_counter.sv
hdl/packet_fifo_with_dedup_and_count_core.sv
dv/packet_fifo_with_dedup_and_count_core_tb.sv
